// ===== src/sic_pkg.sv =====
// package for the segment intersection classifier
// widths, class codes and shared types; no dependencies
package sic_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_BITS   = 24;
  // differences of coordinates
  localparam int DIFF_BITS  = COORD_BITS + 1;
  // cross products
  localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
  // magnitudes of cross products
  localparam int MAG_BITS   = CROSS_BITS - 1;
  // numerator: |d2| * |z1| * 2^FRAC_BITS
  localparam int NUM_BITS   = DIFF_BITS + MAG_BITS + FRAC_BITS;
  // quotient never exceeds |d2| * 2^FRAC_BITS
  localparam int QUO_BITS   = DIFF_BITS + FRAC_BITS;

  typedef enum logic [1:0] {
    REL_NONE    = 2'd0,
    REL_CROSS   = 2'd1,
    REL_CONTIN  = 2'd2,
    REL_OVERLAP = 2'd3
  } rel_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

// ===== src/sic_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on sic_pkg; numerator NUM_BITS wide, quotient QUO_BITS wide
module sic_div (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [sic_pkg::NUM_BITS-1:0] num,
  input  logic [sic_pkg::MAG_BITS-1:0] den,
  output logic [sic_pkg::QUO_BITS-1:0] quo
);
  import sic_pkg::*;

  localparam int STEPS = QUO_BITS;
  localparam int REM_BITS = MAG_BITS + 1;

  // quotient fits in QUO_BITS since numerator < den * 2^QUO_BITS
  logic [REM_BITS-1:0] rem_r [STEPS+1];
  logic [NUM_BITS-1:0] nm_r  [STEPS+1];
  logic [MAG_BITS-1:0] dn_r  [STEPS+1];
  logic [QUO_BITS-1:0] q_r   [STEPS+1];

  always_comb begin
    rem_r[0] = REM_BITS'(num >> QUO_BITS);
    nm_r[0]  = num;
    dn_r[0]  = den;
    q_r[0]   = '0;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [REM_BITS:0] trial;
    logic [REM_BITS:0] diff;
    always_comb begin
      trial = {rem_r[i], nm_r[i][QUO_BITS-1-i]};
      diff  = trial - {2'b00, dn_r[i]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!diff[REM_BITS]) begin
          rem_r[i+1] <= diff[REM_BITS-1:0];
        end else begin
          rem_r[i+1] <= trial[REM_BITS-1:0];
        end
        q_r[i+1]  <= {q_r[i][QUO_BITS-2:0], ~diff[REM_BITS]};
        nm_r[i+1] <= nm_r[i];
        dn_r[i+1] <= dn_r[i];
      end
    end
  end

  assign quo = q_r[STEPS];

endmodule

// ===== src/segment_intersection_classifier_core.sv =====
// top level of the segment intersection classifier
// depends on sic_pkg and sic_div
//
//  port group   dir  handshake                 payload
//  in_          in   in_valid / in_ready       eight signed endpoint coordinates
//  out_         out  out_valid / out_ready     class, point flag, point x/y
//
// fully pipelined: one word per cycle while the pipe moves. all stages move
// together; when the output stage holds an untaken word and out_ready is
// low, the whole pipe freezes. in_ready is high whenever the pipe can move.
// rst_n clears the valid bits.
module segment_intersection_classifier_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sic_pkg::coord_t               in_first_start_x,
  input  sic_pkg::coord_t               in_first_start_y,
  input  sic_pkg::coord_t               in_first_end_x,
  input  sic_pkg::coord_t               in_first_end_y,
  input  sic_pkg::coord_t               in_second_start_x,
  input  sic_pkg::coord_t               in_second_start_y,
  input  sic_pkg::coord_t               in_second_end_x,
  input  sic_pkg::coord_t               in_second_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_relation_class,
  output logic                          out_point_valid,
  output logic signed [sic_pkg::OUT_BITS-1:0] out_point_x,
  output logic signed [sic_pkg::OUT_BITS-1:0] out_point_y
);
  import sic_pkg::*;

  localparam int DLY = QUO_BITS;
  localparam int D = DIFF_BITS;
  localparam int C = CROSS_BITS;

  typedef logic signed [D-1:0] diff_t;
  typedef logic signed [C-1:0] cross_t;

  // side info travelling beside the divider
  typedef struct packed {
    rel_t                          rel;
    logic                          pv;
    logic signed [OUT_BITS-1:0]    bx;
    logic signed [OUT_BITS-1:0]    by;
    logic                          negx;
    logic                          negy;
  } side_t;

  logic adv;
  logic [DLY+4:0] vld_r;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: register inputs and differences
  coord_t ax_r, ay_r, bx_r, by_r, cx_r, cy_r, dx_r, dy_r;
  diff_t ux_r, uy_r, vx_r, vy_r, acx_r, acy_r, adx_r, ady_r, cax_r, cay_r, cbx_r, cby_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r <= in_first_start_x;  ay_r <= in_first_start_y;
      bx_r <= in_first_end_x;    by_r <= in_first_end_y;
      cx_r <= in_second_start_x; cy_r <= in_second_start_y;
      dx_r <= in_second_end_x;   dy_r <= in_second_end_y;
      ux_r  <= D'(in_first_end_x) - D'(in_first_start_x);
      uy_r  <= D'(in_first_end_y) - D'(in_first_start_y);
      vx_r  <= D'(in_second_end_x) - D'(in_second_start_x);
      vy_r  <= D'(in_second_end_y) - D'(in_second_start_y);
      acx_r <= D'(in_second_start_x) - D'(in_first_start_x);
      acy_r <= D'(in_second_start_y) - D'(in_first_start_y);
      adx_r <= D'(in_second_end_x) - D'(in_first_start_x);
      ady_r <= D'(in_second_end_y) - D'(in_first_start_y);
      cax_r <= D'(in_first_start_x) - D'(in_second_start_x);
      cay_r <= D'(in_first_start_y) - D'(in_second_start_y);
      cbx_r <= D'(in_first_end_x) - D'(in_second_start_x);
      cby_r <= D'(in_first_end_y) - D'(in_second_start_y);
    end
  end

  // stage 2: products
  cross_t p_r [10];
  coord_t ax2_r, ay2_r, bx2_r, by2_r, cx2_r, cy2_r, dx2_r, dy2_r;
  diff_t vx2_r, vy2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= C'(ux_r * acy_r);  p_r[1] <= C'(uy_r * acx_r);   // r11 / z1
      p_r[2] <= C'(ux_r * ady_r);  p_r[3] <= C'(uy_r * adx_r);   // r12
      p_r[4] <= C'(vx_r * cay_r);  p_r[5] <= C'(vy_r * cax_r);   // r21
      p_r[6] <= C'(vx_r * cby_r);  p_r[7] <= C'(vy_r * cbx_r);   // r22
      p_r[8] <= C'(ux_r * vy_r);   p_r[9] <= C'(uy_r * vx_r);    // den
      ax2_r <= ax_r; ay2_r <= ay_r; bx2_r <= bx_r; by2_r <= by_r;
      cx2_r <= cx_r; cy2_r <= cy_r; dx2_r <= dx_r; dy2_r <= dy_r;
      vx2_r <= vx_r; vy2_r <= vy_r;
    end
  end

  // stage 3: cross products, classification, divider operands
  cross_t r11, r12, r21, r22, den;
  logic [1:0] s11, s12, s21, s22;
  coord_t x1lo, x1hi, y1lo, y1hi, x2lo, x2hi, y2lo, y2hi;
  logic xt, yt, ovl, cross_hit, col, hit_c, hit_d;
  logic [MAG_BITS-1:0] kmag, dmag;
  side_t side3_nxt;
  side_t side3_r;
  logic [MAG_BITS-1:0] k3_r, dm3_r;
  logic [D-2:0] mvx3_r, mvy3_r;  // |d2| fits D-1 bits

  function automatic logic [1:0] sgn(cross_t v);
    return {v[C-1], v != '0};
  endfunction

  always_comb begin
    r11 = p_r[0] - p_r[1];
    r12 = p_r[2] - p_r[3];
    r21 = p_r[4] - p_r[5];
    r22 = p_r[6] - p_r[7];
    den = p_r[8] - p_r[9];
    s11 = sgn(r11); s12 = sgn(r12); s21 = sgn(r21); s22 = sgn(r22);
    cross_hit = (s11 != s12) && (s21 != s22);
    col = (s11 == 2'b00) && (s12 == 2'b00);
    x1lo = (ax2_r < bx2_r) ? ax2_r : bx2_r; x1hi = (ax2_r < bx2_r) ? bx2_r : ax2_r;
    y1lo = (ay2_r < by2_r) ? ay2_r : by2_r; y1hi = (ay2_r < by2_r) ? by2_r : ay2_r;
    x2lo = (cx2_r < dx2_r) ? cx2_r : dx2_r; x2hi = (cx2_r < dx2_r) ? dx2_r : cx2_r;
    y2lo = (cy2_r < dy2_r) ? cy2_r : dy2_r; y2hi = (cy2_r < dy2_r) ? dy2_r : cy2_r;
    xt = (x1hi == x2lo) || (x2hi == x1lo);
    yt = (y1hi == y2lo) || (y2hi == y1lo);
    ovl = (x1lo < x2hi && x1hi > x2lo) || (y1lo < y2hi && y1hi > y2lo);
    hit_c = (cx2_r == ax2_r && cy2_r == ay2_r) || (cx2_r == bx2_r && cy2_r == by2_r);
    hit_d = (dx2_r == ax2_r && dy2_r == ay2_r) || (dx2_r == bx2_r && dy2_r == by2_r);
    kmag = r11[C-1] ? MAG_BITS'(-r11) : MAG_BITS'(r11);
    dmag = den[C-1] ? MAG_BITS'(-den) : MAG_BITS'(den);
  end

  always_comb begin
    side3_nxt.negx = vx2_r[D-1];
    side3_nxt.negy = vy2_r[D-1];
    side3_nxt.bx   = OUT_BITS'(signed'(cx2_r)) <<< FRAC_BITS;
    side3_nxt.by   = OUT_BITS'(signed'(cy2_r)) <<< FRAC_BITS;
    side3_nxt.pv   = 1'b0;
    side3_nxt.rel  = REL_NONE;
    if (cross_hit) begin
      side3_nxt.rel = REL_CROSS;
      side3_nxt.pv  = 1'b1;
    end else if (col) begin
      if (xt && yt) begin
        side3_nxt.rel = REL_CONTIN;
        side3_nxt.pv  = hit_c || hit_d;
        if (!hit_c) begin
          side3_nxt.bx = OUT_BITS'(signed'(dx2_r)) <<< FRAC_BITS;
          side3_nxt.by = OUT_BITS'(signed'(dy2_r)) <<< FRAC_BITS;
        end
      end else if (ovl) begin
        side3_nxt.rel = REL_OVERLAP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mvx3_r  <= (D-1)'(vx2_r[D-1] ? -vx2_r : vx2_r);
      mvy3_r  <= (D-1)'(vy2_r[D-1] ? -vy2_r : vy2_r);
      k3_r    <= kmag;
      dm3_r   <= dmag;
      side3_r <= side3_nxt;
    end
  end

  // stage 4: numerators |d2| * |z1| * 2^FRAC_BITS
  logic [NUM_BITS-1:0] numx4_r, numy4_r;
  logic [MAG_BITS-1:0] dm4_r;
  side_t side4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      numx4_r <= NUM_BITS'(mvx3_r * k3_r) << FRAC_BITS;
      numy4_r <= NUM_BITS'(mvy3_r * k3_r) << FRAC_BITS;
      dm4_r   <= dm3_r;
      side4_r <= side3_r;
    end
  end

  // divider stages, side info delayed to match
  logic [QUO_BITS-1:0] qx, qy;
  side_t side_d_r [DLY];

  sic_div u_divx (.clk(clk), .adv(adv), .num(numx4_r), .den(dm4_r), .quo(qx));
  sic_div u_divy (.clk(clk), .adv(adv), .num(numy4_r), .den(dm4_r), .quo(qy));

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d_r[0] <= side4_r;
      for (int i = 1; i < DLY; i++) side_d_r[i] <= side_d_r[i-1];
    end
  end

  // output stage
  side_t so;
  logic signed [OUT_BITS-1:0] px_nxt, py_nxt, offx, offy;
  logic [1:0] rel_r;
  logic pv_r;
  logic signed [OUT_BITS-1:0] px_r, py_r;

  always_comb begin
    so = side_d_r[DLY-1];
    offx = OUT_BITS'(qx);
    offy = OUT_BITS'(qy);
    px_nxt = so.bx;
    py_nxt = so.by;
    if (so.rel == REL_CROSS) begin
      px_nxt = so.negx ? so.bx - offx : so.bx + offx;
      py_nxt = so.negy ? so.by - offy : so.by + offy;
    end
    if (!so.pv) begin
      px_nxt = '0;
      py_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rel_r <= so.rel;
      pv_r  <= so.pv;
      px_r  <= px_nxt;
      py_r  <= py_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DLY+3:0], in_valid};
    end
  end

  assign out_valid          = vld_r[DLY+4];
  assign out_relation_class = rel_r;
  assign out_point_valid    = pv_r;
  assign out_point_x        = px_r;
  assign out_point_y        = py_r;

  // checks
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_x))
    else $error("output word changed while stalled");
  a_cross_pt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_relation_class == REL_CROSS |-> out_point_valid)
    else $error("crossing without point");
  a_nopt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |-> out_point_x == '0 && out_point_y == '0)
    else $error("point not cleared");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("pipe stalled with empty output");

endmodule

// ===== test/sic_checker.sv =====
`timescale 1ns / 100ps
// watches both channels of the segment intersection classifier, predicts each word
// and compares results in order; depends on sic_pkg
module sic_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  sic_pkg::coord_t                     in_pts [8],
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [1:0]                          out_relation_class,
  input  logic                                out_point_valid,
  input  logic signed [sic_pkg::OUT_BITS-1:0] out_point_x,
  input  logic signed [sic_pkg::OUT_BITS-1:0] out_point_y,
  output int                                  fail_count,
  output int                                  pending
);
  import sic_pkg::*;

  typedef struct packed {
    rel_t                rel;
    logic                pv;
    logic [OUT_BITS-1:0] px;
    logic [OUT_BITS-1:0] py;
  } relation_t;

  relation_t expected_q[$];

  function automatic longint orient(longint ax, longint ay, longint bx, longint by,
                                    longint px, longint py);
    return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
  endfunction

  function automatic int side(longint c);
    return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
  endfunction

  // start * 2^frac plus the direction scaled by |z1|/|den|, offset truncated toward zero
  function automatic longint along(longint s, longint e, longint unsigned k,
                                   longint unsigned den);
    longint dd;
    longint unsigned m, off;
    dd  = e - s;
    m   = (dd < 0) ? longint'(-dd) : dd;
    off = (den == 0) ? 0 : ((m * k) << FRAC_BITS) / den;
    return (dd < 0) ? (s <<< FRAC_BITS) - longint'(off) : (s <<< FRAC_BITS) + longint'(off);
  endfunction

  function automatic relation_t classify(coord_t p[8]);
    longint ax, ay, bx, by, cx, cy, dx, dy, z1, den, px, py;
    longint x1lo, x1hi, y1lo, y1hi, x2lo, x2hi, y2lo, y2hi;
    int r11, r12, r21, r22;
    relation_t r;
    ax = p[0]; ay = p[1]; bx = p[2]; by = p[3];
    cx = p[4]; cy = p[5]; dx = p[6]; dy = p[7];
    r11 = side(orient(ax, ay, bx, by, cx, cy));
    r12 = side(orient(ax, ay, bx, by, dx, dy));
    r21 = side(orient(cx, cy, dx, dy, ax, ay));
    r22 = side(orient(cx, cy, dx, dy, bx, by));
    r = '0;
    r.rel = REL_NONE;
    if (r11 != r12 && r21 != r22) begin
      z1  = orient(ax, ay, bx, by, cx, cy);
      den = (bx - ax) * (dy - cy) - (by - ay) * (dx - cx);
      px  = along(cx, dx, (z1 < 0) ? -z1 : z1, (den < 0) ? -den : den);
      py  = along(cy, dy, (z1 < 0) ? -z1 : z1, (den < 0) ? -den : den);
      r.rel = REL_CROSS;
      r.pv  = 1'b1;
      r.px  = px[OUT_BITS-1:0];
      r.py  = py[OUT_BITS-1:0];
    end else if (r11 == 0 && r12 == 0) begin
      x1lo = (ax < bx) ? ax : bx;  x1hi = (ax < bx) ? bx : ax;
      y1lo = (ay < by) ? ay : by;  y1hi = (ay < by) ? by : ay;
      x2lo = (cx < dx) ? cx : dx;  x2hi = (cx < dx) ? dx : cx;
      y2lo = (cy < dy) ? cy : dy;  y2hi = (cy < dy) ? dy : cy;
      if ((x1hi == x2lo || x2hi == x1lo) && (y1hi == y2lo || y2hi == y1lo)) begin
        r.rel = REL_CONTIN;
        // shared endpoint: second start wins over second end
        if ((cx == ax && cy == ay) || (cx == bx && cy == by)) begin
          px = cx <<< FRAC_BITS;  py = cy <<< FRAC_BITS;
          r.pv = 1'b1;  r.px = px[OUT_BITS-1:0];  r.py = py[OUT_BITS-1:0];
        end else if ((dx == ax && dy == ay) || (dx == bx && dy == by)) begin
          px = dx <<< FRAC_BITS;  py = dy <<< FRAC_BITS;
          r.pv = 1'b1;  r.px = px[OUT_BITS-1:0];  r.py = py[OUT_BITS-1:0];
        end
      end else if ((x1lo < x2hi && x1hi > x2lo) || (y1lo < y2hi && y1hi > y2lo)) begin
        r.rel = REL_OVERLAP;
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    relation_t w;
    if (rst_n) begin
      if (in_valid && in_ready) expected_q.push_back(classify(in_pts));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected word", out_relation_class, 0);
        end else begin
          w = expected_q.pop_front();
          if (out_relation_class !== w.rel) report("relation_class", out_relation_class, w.rel);
          if (out_point_valid !== w.pv) report("point_valid", out_point_valid, w.pv);
          if (out_point_x !== w.px) report("point_x", out_point_x, w.px);
          if (out_point_y !== w.py) report("point_y", out_point_y, w.py);
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for the segment intersection classifier core;
// depends on sic_pkg, segment_intersection_classifier_core and sic_checker
module tb_top;
  import sic_pkg::*;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  coord_t in_pts [8];
  logic [1:0] out_relation_class;
  logic out_point_valid;
  logic signed [OUT_BITS-1:0] out_point_x, out_point_y;
  int fail_count, pending;
  bit long_hold;

  segment_intersection_classifier_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_first_start_x(in_pts[0]), .in_first_start_y(in_pts[1]),
    .in_first_end_x(in_pts[2]), .in_first_end_y(in_pts[3]),
    .in_second_start_x(in_pts[4]), .in_second_start_y(in_pts[5]),
    .in_second_end_x(in_pts[6]), .in_second_end_y(in_pts[7]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_relation_class(out_relation_class), .out_point_valid(out_point_valid),
    .out_point_x(out_point_x), .out_point_y(out_point_y)
  );

  sic_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_pts(in_pts),
    .out_valid(out_valid), .out_ready(out_ready), .out_relation_class(out_relation_class),
    .out_point_valid(out_point_valid), .out_point_x(out_point_x),
    .out_point_y(out_point_y), .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  // receiver: stall pattern switches between four randomly chosen modes
  initial begin
    int mode, cnt;
    out_ready = 1'b0;
    mode = 0;
    cnt = 0;
    forever begin
      @(negedge clk);
      if (cnt == 0) begin
        mode = $urandom_range(0, 3);
        cnt = 64;
      end
      cnt--;
      if (long_hold) out_ready = 1'b0;
      else case (mode)
        0: out_ready = 1'b1;
        1: out_ready = $urandom_range(0, 1);
        2: out_ready = ($urandom_range(0, 3) == 0);
        default: out_ready = (cnt % 8) < 5;
      endcase
    end
  end

  task automatic send_word(input coord_t c[8]);
    @(negedge clk);
    in_pts = c;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic coord_t rnd_coord(input int span);
    if (span == 0) return coord_t'($urandom());
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic send_list(input int a, b, c, d, e, f, g, h);
    coord_t w[8];
    w = '{coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d),
          coord_t'(e), coord_t'(f), coord_t'(g), coord_t'(h)};
    send_word(w);
  endtask

  // one random segment pair; kinds lean toward collinear and touching cases
  task automatic send_random();
    coord_t w[8];
    int kind, span, bx, by, dx, dy, t0, t1;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(2, 14));
    for (int i = 0; i < 8; i++) w[i] = rnd_coord(span);
    if (kind < 4) begin
      // second segment on the first one's line
      bx = $urandom_range(0, 200) - 100;  by = $urandom_range(0, 200) - 100;
      dx = $urandom_range(0, 6) - 3;      dy = $urandom_range(0, 6) - 3;
      t0 = $urandom_range(0, 8) - 4;      t1 = $urandom_range(0, 8) - 4;
      w[0] = coord_t'(bx);  w[1] = coord_t'(by);
      w[2] = coord_t'(bx + 2 * dx);  w[3] = coord_t'(by + 2 * dy);
      w[4] = coord_t'(bx + t0 * dx);  w[5] = coord_t'(by + t0 * dy);
      w[6] = coord_t'(bx + t1 * dx);  w[7] = coord_t'(by + t1 * dy);
      if (kind == 0) begin
        w[4] = w[2];  w[5] = w[3];
      end
    end else if (kind == 4) begin
      // touching at a shared endpoint
      w[4] = w[$urandom_range(0, 1) * 2];
      w[5] = w[4] == w[0] ? w[1] : w[3];
    end else if (kind == 5) begin
      w[0] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      w[7] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    send_word(w);
  endtask

  initial begin
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    long_hold = 1'b0;
    for (int i = 0; i < 8; i++) in_pts[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words
    send_list(-4, 0, 4, 0, 0, -4, 0, 4);                 // proper crossing
    send_list(0, 0, 3, 7, 0, 5, 2, -1);                  // crossing, fractional point
    send_list(0, 0, 4, 4, 4, 4, 8, 0);                   // touching at an endpoint
    send_list(0, 0, 4, 0, 4, 0, 9, 0);                   // continuation, start shared
    send_list(0, 0, 4, 0, -3, 0, 0, 0);                  // continuation, end shared
    send_list(0, 0, 0, 0, 0, 3, 5, 0);                   // continuation, no shared point
    send_list(0, 0, 6, 6, 2, 2, 9, 9);                   // collinear overlap
    send_list(0, 0, 2, 0, 5, 0, 9, 0);                   // collinear, disjoint
    send_list(0, 0, 4, 0, 0, 1, 4, 1);                   // parallel
    send_list(3, 3, 3, 3, 3, 3, 3, 3);                   // both degenerate, same spot
    send_list(1, 1, 1, 1, 0, 0, 5, 5);                   // degenerate on the other line
    send_list(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_list(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
    send_list(-32768, 0, 32767, 0, 0, -32768, 1, 32767);
    send_list(-32768, -32768, -32768, 32767, -32768, 32767, -32768, -32768);
    send_list(32767, -32768, -32768, 32767, 0, 0, -1, 1);
    send_list(0, 0, 0, 0, 0, 0, 0, 0);
    send_list(-1, -1, -1, -1, -1, -1, -1, -1);
    gap(1);
    wait (pending == 0);

    // long receiver hold while words keep coming
    fork
      begin
        long_hold = 1'b1;
        repeat (200) @(negedge clk);
        long_hold = 1'b0;
      end
      repeat (80) send_random();
    join

    burst = 0;
    for (int n = 0; n < 1200; n++) begin
      if (burst == 0) begin
        gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
        burst = $urandom_range(1, 40);
      end
      burst--;
      if (n == 600) begin
        gap(1);
        wait (pending == 0);
      end
      send_random();
    end
    gap(1);

    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
